@@ src/reb_pkg.sv @@
// ----------------------------------------------------------------------------
// reb_pkg
// shared codes, widths and timing constants for the rotary encoder and
// push button event decoder
// ----------------------------------------------------------------------------
package reb_pkg;

  localparam int COUNT_W = 16;
  localparam int TIMER_W = 7;
  localparam int PERIOD_W = 5;

  // event codes
  localparam logic [2:0] EV_IDLE       = 3'd0;
  localparam logic [2:0] EV_LEFT       = 3'd1;
  localparam logic [2:0] EV_RIGHT      = 3'd2;
  localparam logic [2:0] EV_LEFT_FAST  = 3'd3;
  localparam logic [2:0] EV_RIGHT_FAST = 3'd4;
  localparam logic [2:0] EV_PRESS      = 3'd5;
  localparam logic [2:0] EV_LONG       = 3'd6;
  localparam logic [2:0] EV_HELD       = 3'd7;

  // item kinds
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  // poll modes
  localparam logic MODE_DIR  = 1'b0;
  localparam logic MODE_FAST = 1'b1;

  // button timing
  localparam logic [TIMER_W-1:0]  DEBOUNCE_TICKS    = 7'd5;
  localparam logic [TIMER_W-1:0]  HOLD_PERIOD_TICKS = 7'd100;
  localparam logic [PERIOD_W-1:0] LONG_HOLD_PERIODS = 5'd30;

  // step counter
  localparam logic [COUNT_W-1:0] STEP_GAIN  = 16'd5;
  localparam logic [COUNT_W-1:0] FAST_LIMIT = 16'd20;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

  // button write toward the pending event
  typedef struct packed {
    logic       wr;
    logic [2:0] code;
  } btn_evt_t;

endpackage

@@ src/reb_if.sv @@
// ----------------------------------------------------------------------------
// reb_item_if / reb_event_if
// valid/ready channels for input items and result events
// ----------------------------------------------------------------------------
interface reb_item_if;
  logic valid;
  logic ready;
  logic func;
  logic chan_a;
  logic chan_b;
  logic button_level;
  logic poll_mode;

  modport source (output valid, func, chan_a, chan_b, button_level, poll_mode,
                  input ready);
  modport sink (input valid, func, chan_a, chan_b, button_level, poll_mode,
                output ready);
endinterface

interface reb_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;

  modport source (output valid, event_code, input ready);
  modport sink (input valid, event_code, output ready);
endinterface

@@ src/rotary_encoder_button_events.sv @@
// ----------------------------------------------------------------------------
// rotary_encoder_button_events
// rotary encoder and push button event decoder with poll interface
// ----------------------------------------------------------------------------
// Items arrive on the items channel: a sample tick (func 0) carries the levels
// of encoder channels A and B and of the push button; a poll (func 1) carries
// a mode and returns one event code on the events channel. Ticks return
// nothing. A rising edge of A counts a left step when B is at active_level,
// else a right step, adding 5 to the matching saturating step counter and
// setting the pending event. The button is debounced over 5 ticks, reports
// held every 100 ticks while down, long press after 30 periods, and press or
// long press on release; a button event overrides an encoder edge in the same
// tick. A poll in direction mode picks the larger count, in fast mode flags a
// count above 20 (right wins), else returns the pending event; clears all three.
// Timing: one item per clock unless a poll waits on the output register; an
// item is registered in the input register and a poll result appears in the
// output register on the next cycle. The output register holds a result while
// the sink stalls; ticks flow behind it, only a poll waits for it to free up.
// ----------------------------------------------------------------------------
module rotary_encoder_button_events #(
  parameter logic [reb_pkg::TIMER_W-1:0]  DEBOUNCE_TICKS    = reb_pkg::DEBOUNCE_TICKS,
  parameter logic [reb_pkg::TIMER_W-1:0]  HOLD_PERIOD_TICKS = reb_pkg::HOLD_PERIOD_TICKS,
  parameter logic [reb_pkg::PERIOD_W-1:0] LONG_HOLD_PERIODS = reb_pkg::LONG_HOLD_PERIODS
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  reb_item_if.sink    items,
  reb_event_if.source events
);
  import reb_pkg::*;

  // configuration
  logic active_level;

  // input register
  logic s1_valid;
  logic s1_func, s1_a, s1_b, s1_btn, s1_mode;
  logic s1_adv;

  // decoder state
  logic               prev_chan_a;
  logic [COUNT_W-1:0] left_count, left_count_next;
  logic [COUNT_W-1:0] right_count, right_count_next;
  logic [2:0]         pending_event, pending_event_next;

  // output register
  logic       out_valid;
  logic [2:0] out_code;

  logic     tick, poll;
  logic     a_rise;
  btn_evt_t btn_evt;
  logic [COUNT_W:0] left_sum, right_sum;
  logic [2:0] poll_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_level <= 1'b0;
    end else if (cfg_wr_en) begin
      active_level <= cfg_wr_data;
    end
  end

  // a tick never blocks; a poll needs the output register free or draining
  assign s1_adv = s1_valid && (s1_func == FUNC_TICK || !out_valid || events.ready);
  assign items.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      s1_func <= items.func;
      s1_a    <= items.chan_a;
      s1_b    <= items.chan_b;
      s1_btn  <= items.button_level;
      s1_mode <= items.poll_mode;
    end
  end

  assign tick   = s1_adv && s1_func == FUNC_TICK;
  assign poll   = s1_adv && s1_func == FUNC_POLL;
  assign a_rise = !prev_chan_a && s1_a;

  // saturating step adds
  assign left_sum  = {1'b0, left_count} + {1'b0, STEP_GAIN};
  assign right_sum = {1'b0, right_count} + {1'b0, STEP_GAIN};

  reb_button #(
    .DEBOUNCE_TICKS    (DEBOUNCE_TICKS),
    .HOLD_PERIOD_TICKS (HOLD_PERIOD_TICKS),
    .LONG_HOLD_PERIODS (LONG_HOLD_PERIODS)
  ) u_button (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .active (s1_btn == active_level),
    .evt    (btn_evt)
  );

  // poll decision on the counts before they are cleared
  always_comb begin
    poll_event = pending_event;
    if (s1_mode == MODE_DIR) begin
      if (left_count > right_count) begin
        poll_event = EV_LEFT;
      end else if (left_count < right_count) begin
        poll_event = EV_RIGHT;
      end
    end else begin
      if (left_count > FAST_LIMIT) begin
        poll_event = EV_LEFT_FAST;
      end
      if (right_count > FAST_LIMIT) begin
        poll_event = EV_RIGHT_FAST;
      end
    end
  end

  always_comb begin
    left_count_next    = left_count;
    right_count_next   = right_count;
    pending_event_next = pending_event;
    if (tick) begin
      if (a_rise) begin
        if (s1_b == active_level) begin
          left_count_next    = left_sum[COUNT_W] ? COUNT_MAX : left_sum[COUNT_W-1:0];
          pending_event_next = EV_LEFT;
        end else begin
          right_count_next   = right_sum[COUNT_W] ? COUNT_MAX : right_sum[COUNT_W-1:0];
          pending_event_next = EV_RIGHT;
        end
      end
      // button wins over an encoder edge in the same tick
      if (btn_evt.wr) begin
        pending_event_next = btn_evt.code;
      end
    end else if (poll) begin
      left_count_next    = '0;
      right_count_next   = '0;
      pending_event_next = EV_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_chan_a   <= 1'b0;
      left_count    <= '0;
      right_count   <= '0;
      pending_event <= EV_IDLE;
    end else begin
      if (tick) begin
        prev_chan_a <= s1_a;
      end
      left_count    <= left_count_next;
      right_count   <= right_count_next;
      pending_event <= pending_event_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (poll) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll) begin
      out_code <= poll_event;
    end
  end

  assign events.valid      = out_valid;
  assign events.event_code = out_code;

  // a poll leaves counts and pending event cleared
  a_poll_clears: assert property (@(posedge clk) disable iff (rst)
    poll |=> (left_count == '0 && right_count == '0 && pending_event == EV_IDLE))
    else $error("poll did not clear decoder state");

  // a waiting result is never overwritten by a new poll
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !events.ready) |-> !poll)
    else $error("poll result overwrote a waiting event");

  // an empty input register always takes an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> items.ready)
    else $error("input stalled with empty input register");

endmodule

@@ src/reb_button.sv @@
// ----------------------------------------------------------------------------
// reb_button
// push button debounce and hold timer, run once per sample tick
// ----------------------------------------------------------------------------
module reb_button #(
  parameter logic [reb_pkg::TIMER_W-1:0]  DEBOUNCE_TICKS    = reb_pkg::DEBOUNCE_TICKS,
  parameter logic [reb_pkg::TIMER_W-1:0]  HOLD_PERIOD_TICKS = reb_pkg::HOLD_PERIOD_TICKS,
  parameter logic [reb_pkg::PERIOD_W-1:0] LONG_HOLD_PERIODS = reb_pkg::LONG_HOLD_PERIODS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              active,
  output reb_pkg::btn_evt_t evt
);
  import reb_pkg::*;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_HELD     = 2'd2;

  logic [1:0]          phase, phase_next;
  logic [TIMER_W-1:0]  timer, timer_next, timer_inc;
  logic [PERIOD_W-1:0] periods, periods_next;

  assign timer_inc = timer + 1'b1;

  always_comb begin
    phase_next   = phase;
    timer_next   = timer;
    periods_next = periods;
    evt.wr       = 1'b0;
    evt.code     = EV_IDLE;
    if (tick) begin
      case (phase)
        PH_DEBOUNCE: begin
          timer_next = timer_inc;
          if (timer_inc >= DEBOUNCE_TICKS) begin
            timer_next   = '0;
            periods_next = '0;
            phase_next   = active ? PH_HELD : PH_IDLE;
          end
        end
        PH_HELD: begin
          if (!active) begin
            // release
            evt.wr     = 1'b1;
            evt.code   = (periods >= LONG_HOLD_PERIODS) ? EV_LONG : EV_PRESS;
            phase_next = PH_IDLE;
            timer_next = '0;
          end else begin
            timer_next = timer_inc;
            if (timer_inc >= HOLD_PERIOD_TICKS) begin
              timer_next = '0;
              evt.wr     = 1'b1;
              if (periods < LONG_HOLD_PERIODS) begin
                evt.code     = EV_HELD;
                periods_next = periods + 1'b1;
              end else begin
                evt.code = EV_LONG;
              end
            end
          end
        end
        default: begin
          phase_next = active ? PH_DEBOUNCE : PH_IDLE;
          if (active) begin
            timer_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      timer   <= '0;
      periods <= '0;
    end else begin
      phase   <= phase_next;
      timer   <= timer_next;
      periods <= periods_next;
    end
  end

endmodule
